// ----- rtl/srr_pkg.sv -----
// Shared types, status codes and default sizes for the segment reorder receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srr_pkg;

  // Defaults for the top level parameters
  localparam int SRR_SLOTS        = 8;
  localparam int SRR_SEGMENT_SIZE = 1024;

  localparam logic [15:0] WINDOW_MAX = 16'hFFFF;

  // Input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_OPEN = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OPENED   = 3'd0;
  localparam logic [2:0] ST_IN_ORDER = 3'd1;
  localparam logic [2:0] ST_BUFFERED = 3'd2;
  localparam logic [2:0] ST_ALREADY  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_OLD      = 3'd5;

  // One reorder slot as stored in the slot memory
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] len;
  } srr_entry_t;

  // One result beat
  typedef struct packed {
    logic [3:0]  free_slots;
    logic [31:0] reorder_count;
    logic [31:0] sum_bytes;
    logic [19:0] delivered_bytes;
    logic [15:0] window_bytes;
    logic [15:0] ack_number;
  } srr_result_t;

endpackage

// ----- rtl/srr_slot_mem.sv -----
// Slot memory: sequence number and length of each buffered segment.
// One write port, one read port, read data registered. Uses srr_pkg.
`timescale 1ns / 1ps

module srr_slot_mem #(
  parameter int DEPTH = srr_pkg::SRR_SLOTS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  srr_pkg::srr_entry_t wr_data,
  input  logic [AW-1:0]      rd_addr,
  output srr_pkg::srr_entry_t rd_data
);
  import srr_pkg::*;

  srr_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/srr_ctrl.sv -----
// Sequencer of the reorder receiver: classifies a segment, scans the slot
// memory for drains or duplicates, inserts, and keeps the counters. Uses srr_pkg.
`timescale 1ns / 1ps

module srr_ctrl #(
  parameter int SLOTS        = srr_pkg::SRR_SLOTS,
  parameter int SEGMENT_SIZE = srr_pkg::SRR_SEGMENT_SIZE,
  parameter int AW           = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [15:0]          in_seq,
  input  logic [15:0]          in_len,
  // result out
  output logic                 res_valid,
  input  logic                 res_take,
  output srr_pkg::srr_result_t res,
  output logic [2:0]           res_status,
  // slot memory
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output srr_pkg::srr_entry_t  mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  srr_pkg::srr_entry_t  mem_rdata
);
  import srr_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r,   state_nxt;
  logic [AW-1:0]    ptr_r,     ptr_nxt;
  logic [AW-1:0]    idx_r,     idx_nxt;
  logic             chk_r,     chk_nxt;
  logic [CW-1:0]    miss_r,    miss_nxt;
  logic             drain_r,   drain_nxt;
  logic             held_r,    held_nxt;
  logic [15:0]      ne_r,      ne_nxt;
  logic [31:0]      total_r,   total_nxt;
  logic [31:0]      reorder_r, reorder_nxt;
  logic [19:0]      dlv_r,     dlv_nxt;
  logic [2:0]       status_r,  status_nxt;
  logic [SLOTS-1:0] valid_r,   valid_nxt;
  logic [15:0]      seq_r,     seq_nxt;
  logic [15:0]      len_r,     len_nxt;

  logic [15:0]   diff;
  logic          hit_drain, hit_held, last_cmp, free_any;
  logic [AW-1:0] free_idx;
  logic [CW-1:0] miss_inc;
  logic [3:0]    free_cnt;
  logic [19:0]   win_full;

  // lowest free slot and free count
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    free_cnt = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
        free_cnt = free_cnt + 4'd1;
      end
    end
  end

  assign diff      = in_seq - ne_r;
  assign hit_drain = chk_r && valid_r[idx_r] && (mem_rdata.seq == ne_r);
  assign hit_held  = chk_r && valid_r[idx_r] && (mem_rdata.seq == seq_r);
  assign miss_inc  = miss_r + CW'(1);
  assign last_cmp  = chk_r && (miss_inc == CW'(SLOTS));

  assign in_ready  = (state_r == S_IDLE);
  assign mem_raddr = ptr_r;
  assign mem_waddr = free_idx;
  assign mem_wdata = '{seq: seq_r, len: len_r};

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    idx_nxt     = idx_r;
    chk_nxt     = chk_r;
    miss_nxt    = miss_r;
    drain_nxt   = drain_r;
    held_nxt    = held_r;
    ne_nxt      = ne_r;
    total_nxt   = total_r;
    reorder_nxt = reorder_r;
    dlv_nxt     = dlv_r;
    status_nxt  = status_r;
    valid_nxt   = valid_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    mem_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seq_nxt  = in_seq;
          len_nxt  = in_len;
          dlv_nxt  = '0;
          ptr_nxt  = '0;
          chk_nxt  = 1'b0;
          miss_nxt = '0;
          held_nxt = 1'b0;
          if (in_op == OP_OPEN) begin
            ne_nxt     = in_seq + 16'd1;
            status_nxt = ST_OPENED;
            state_nxt  = S_DONE;
          end else if (diff == 16'd0) begin
            ne_nxt     = ne_r + in_len;
            total_nxt  = total_r + 32'(in_len);
            dlv_nxt    = 20'(in_len);
            status_nxt = ST_IN_ORDER;
            drain_nxt  = 1'b1;
            state_nxt  = S_SCAN;
          end else if (!diff[15]) begin
            drain_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            status_nxt = ST_OLD;
            state_nxt  = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compared the cycle after
        ptr_nxt = (ptr_r == AW'(SLOTS - 1)) ? '0 : ptr_r + AW'(1);
        idx_nxt = ptr_r;
        chk_nxt = 1'b1;
        if (chk_r) begin
          if (drain_r) begin
            // circular scan; a full lap without a match ends the drain
            if (hit_drain) begin
              ne_nxt           = ne_r + mem_rdata.len;
              total_nxt        = total_r + 32'(mem_rdata.len);
              dlv_nxt          = dlv_r + 20'(mem_rdata.len);
              valid_nxt[idx_r] = 1'b0;
              miss_nxt         = '0;
            end else if (last_cmp) begin
              chk_nxt   = 1'b0;
              state_nxt = S_DONE;
            end else begin
              miss_nxt = miss_inc;
            end
          end else begin
            miss_nxt = miss_inc;
            held_nxt = held_r | hit_held;
            if (last_cmp) begin
              chk_nxt   = 1'b0;
              state_nxt = S_DONE;
              if (held_r || hit_held) begin
                status_nxt = ST_ALREADY;
              end else if (free_any) begin
                mem_we              = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                reorder_nxt         = reorder_r + 32'd1;
                status_nxt          = ST_BUFFERED;
              end else begin
                status_nxt = ST_FULL;
              end
            end
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_r     <= 1'b0;
      ptr_r     <= '0;
      miss_r    <= '0;
      ne_r      <= '0;
      total_r   <= '0;
      reorder_r <= '0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_r     <= chk_nxt;
      ptr_r     <= ptr_nxt;
      miss_r    <= miss_nxt;
      ne_r      <= ne_nxt;
      total_r   <= total_nxt;
      reorder_r <= reorder_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    drain_r  <= drain_nxt;
    held_r   <= held_nxt;
    dlv_r    <= dlv_nxt;
    status_r <= status_nxt;
    seq_r    <= seq_nxt;
    len_r    <= len_nxt;
  end

  // window = free slots * segment size, saturated
  assign win_full = 20'(free_cnt) * 20'(SEGMENT_SIZE);

  assign res_valid           = (state_r == S_DONE);
  assign res_status          = status_r;
  assign res.ack_number      = ne_r;
  assign res.window_bytes    = (win_full > 20'(WINDOW_MAX)) ? WINDOW_MAX : win_full[15:0];
  assign res.delivered_bytes = dlv_r;
  assign res.sum_bytes       = total_r;
  assign res.reorder_count   = reorder_r;
  assign res.free_slots      = free_cnt;

endmodule

// ----- rtl/segment_reorder_receiver.sv -----
// Open and old segments go straight to the result; ahead and in-order segments
// first scan every slot, and an in-order segment's drain keeps scanning while it
// finds the next segment in some slot (one memory read per cycle).
// Throughput: one item at a time; the next input beat is taken once the result
// has moved to the output register. Reset (rst_n low, synchronous) empties all
// slots and clears next-expected and both counters; slot memory needs no clearing.
`timescale 1ns / 1ps

module segment_reorder_receiver #(
  parameter int SLOTS        = srr_pkg::SRR_SLOTS,        // 1..15
  parameter int SEGMENT_SIZE = srr_pkg::SRR_SEGMENT_SIZE  // 1..65535
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] seq_num, [31:16] seg_length
  input  logic         in_tuser,   // operation: 0 data segment, 1 connection open
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // ack_number[15:0], window_bytes[31:16],
                                   // delivered_bytes[51:32], sum_bytes[83:52],
                                   // reorder_count[115:84], free_slots[119:116]
  output logic [2:0]   out_tuser   // status
);
  import srr_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  srr_result_t res;
  logic [2:0]  res_status;
  logic        res_valid, res_take;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  srr_entry_t    mem_wdata, mem_rdata;

  // output register state
  logic         out_valid_r, out_valid_nxt;
  srr_result_t  out_res_r;
  logic [2:0]   out_status_r;

  // The sequencer hands its result over as soon as the output register is
  // empty or being emptied this cycle; until then a waiting result blocks intake.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  srr_ctrl #(
    .SLOTS        (SLOTS),
    .SEGMENT_SIZE (SEGMENT_SIZE),
    .AW           (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_seq     (in_tdata[15:0]),
    .in_len     (in_tdata[31:16]),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .res_status (res_status),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Slot sequence numbers and lengths; validity lives in flops in the sequencer.
  srr_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on handover
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r    <= res;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- tb/reorder_scoreboard_pkg.sv -----
// Scoreboard for the segment reorder receiver: a cycle-free model of the
// reorder slots and counters plus the queue of ack beats still to arrive.
// Depends on srr_pkg for the result layout, status codes and default sizes.
`timescale 1ns / 1ps

package reorder_scoreboard_pkg;
  import srr_pkg::*;

  typedef struct {
    srr_result_t fields;
    logic [2:0]  status;
  } ack_beat_t;

  class reorder_scoreboard;
    bit        held     [SRR_SLOTS];
    bit [15:0] held_seq [SRR_SLOTS];
    bit [15:0] held_len [SRR_SLOTS];
    bit [15:0] ack_next;
    bit [31:0] byte_total;
    bit [31:0] reorder_total;
    ack_beat_t pending_acks[$];
    int        errors;
    int        shown;

    function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < SRR_SLOTS; i++)
        if (!held[i]) n++;
      return n;
    endfunction

    function int pending();
      return pending_acks.size();
    endfunction

    // Update the model with one accepted input beat and queue its ack
    function void apply_segment(logic op, logic [15:0] seq, logic [15:0] len);
      ack_beat_t   e;
      logic [15:0] offset;
      logic [19:0] got;
      logic [2:0]  st;
      int          slot;
      bit          dup;
      bit          moved;
      int          nfree;
      int unsigned win;
      got = '0;
      if (op == OP_OPEN) begin
        ack_next = seq + 16'd1;
        st = ST_OPENED;
      end else begin
        offset = seq - ack_next;
        if (offset == 16'd0) begin
          ack_next   = ack_next + len;
          byte_total = byte_total + 32'(len);
          got = 20'(len);
          // drain passes repeat until a full scan finds nothing
          moved = 1'b1;
          while (moved) begin
            moved = 1'b0;
            for (int i = 0; i < SRR_SLOTS; i++) begin
              if (held[i] && held_seq[i] == ack_next) begin
                ack_next   = ack_next + held_len[i];
                byte_total = byte_total + 32'(held_len[i]);
                got        = got + 20'(held_len[i]);
                held[i]    = 1'b0;
                moved      = 1'b1;
              end
            end
          end
          st = ST_IN_ORDER;
        end else if (offset < 16'h8000) begin
          dup  = 1'b0;
          slot = -1;
          for (int i = 0; i < SRR_SLOTS; i++)
            if (held[i] && held_seq[i] == seq) dup = 1'b1;
          for (int i = 0; i < SRR_SLOTS; i++)
            if (!held[i] && slot < 0) slot = i;
          if (dup) begin
            st = ST_ALREADY;
          end else if (slot >= 0) begin
            held[slot]     = 1'b1;
            held_seq[slot] = seq;
            held_len[slot] = len;
            reorder_total  = reorder_total + 1;
            st = ST_BUFFERED;
          end else begin
            st = ST_FULL;
          end
        end else begin
          st = ST_OLD;
        end
      end
      nfree = free_count();
      win   = nfree * SRR_SEGMENT_SIZE;
      if (win > 32'(WINDOW_MAX)) win = 32'(WINDOW_MAX);
      e.fields.ack_number      = ack_next;
      e.fields.window_bytes    = win[15:0];
      e.fields.delivered_bytes = got;
      e.fields.sum_bytes       = byte_total;
      e.fields.reorder_count   = reorder_total;
      e.fields.free_slots      = 4'(nfree);
      e.status                 = st;
      pending_acks.push_back(e);
    endfunction

    function void report(string what);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("[%0t] %s", $time, what);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
        report($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    function void check_ack(logic [119:0] data, logic [2:0] user);
      ack_beat_t   e;
      srr_result_t got;
      got = srr_result_t'(data);
      if (pending_acks.size() == 0) begin
        report($sformatf("unexpected result beat: data %0h status %0d", data, user));
        return;
      end
      e = pending_acks.pop_front();
      compare_field("ack_number", 32'(e.fields.ack_number), 32'(got.ack_number));
      compare_field("window_bytes", 32'(e.fields.window_bytes), 32'(got.window_bytes));
      compare_field("delivered_bytes", 32'(e.fields.delivered_bytes),
                    32'(got.delivered_bytes));
      compare_field("sum_bytes", e.fields.sum_bytes, got.sum_bytes);
      compare_field("reorder_count", e.fields.reorder_count, got.reorder_count);
      compare_field("free_slots", 32'(e.fields.free_slots), 32'(got.free_slots));
      compare_field("status", 32'(e.status), 32'(user));
    endfunction

    function void flush_leftover();
      ack_beat_t e;
      while (pending_acks.size() != 0) begin
        e = pending_acks.pop_front();
        report($sformatf("result beat never arrived: ack %0h status %0d",
                         e.fields.ack_number, e.status));
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top level testbench for segment_reorder_receiver: directed segments, then
// shuffled sender bursts and noise under changing backpressure.
// Depends on srr_pkg, reorder_scoreboard_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import srr_pkg::*;
  import reorder_scoreboard_pkg::*;

  // worst case internal latency: a drain chaining through every slot
  localparam int DRAIN_CYCLES = SRR_SLOTS * SRR_SLOTS + 4;
  localparam int HOLD_CYCLES  = 240;
  localparam int PLAN_DEPTH   = 10;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;    // [15:0] seq_num, [31:16] seg_length
  logic         in_tuser   = 1'b0;  // operation
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;          // ack, window, delivered, total, reorder, free
  logic [2:0]   out_tuser;          // status

  reorder_scoreboard sb = new();

  // backpressure knobs, set by the stimulus process
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int beats_sent  = 0;

  // sender's planned byte stream: fixed segment boundaries so that
  // retransmitted pieces line up with what is already buffered
  logic [15:0] plan_seq[$];
  logic [15:0] plan_len[$];

  segment_reorder_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  // The hold length is counted here, independent of the sender.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result monitor; values read here are the ones sampled at this edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_ack(out_tdata, out_tuser);
  end

  // Offer a beat and hold it until taken. Called right after posedge clk.
  task automatic send_item(input logic op, input logic [15:0] seq, input logic [15:0] len);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {len, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_segment(op, seq, len);
    beats_sent++;
  endtask

  // Sender goes quiet until every expected ack has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Line the plan up with the receiver's ack point and top it up
  task automatic sync_plan();
    logic [15:0] gap;
    logic [15:0] nxt;
    while (plan_seq.size() != 0) begin
      gap = plan_seq[0] - sb.ack_next;
      if (gap == 16'd0 || gap < 16'h8000) break;
      void'(plan_seq.pop_front());
      void'(plan_len.pop_front());
    end
    if (plan_seq.size() == 0 || plan_seq[0] != sb.ack_next) begin
      plan_seq.delete();
      plan_len.delete();
    end
    while (plan_seq.size() < PLAN_DEPTH) begin
      nxt = (plan_seq.size() == 0) ? sb.ack_next : plan_seq[$] + plan_len[$];
      plan_seq.push_back(nxt);
      plan_len.push_back(($urandom_range(0, 9) == 0) ? 16'($urandom_range(1461, 3000))
                                                     : 16'($urandom_range(1, 1460)));
    end
  endtask

  // A window of segments from the ack point, in order, reversed or shuffled,
  // with the odd loss and the odd repeat
  task automatic send_burst();
    logic [15:0] bseq[PLAN_DEPTH];
    logic [15:0] blen[PLAN_DEPTH];
    int          order[PLAN_DEPTH];
    int          n;
    int          j;
    int          t;
    int          how;
    sync_plan();
    n   = $urandom_range(1, PLAN_DEPTH);
    how = $urandom_range(0, 9);
    for (int i = 0; i < PLAN_DEPTH; i++) begin
      bseq[i]  = plan_seq[i];
      blen[i]  = plan_len[i];
      order[i] = (how < 2) ? n - 1 - i : i;
    end
    if (how >= 5) begin
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) >= 8) begin
        send_item(OP_DATA, bseq[order[i]], blen[order[i]]);
        if ($urandom_range(0, 99) < 8)
          send_item(OP_DATA, bseq[order[i]], blen[order[i]]);
      end
    end
  endtask

  // Stale slot that will never chain: jump the ack point onto it and send
  // a zero-length segment so the drain picks it up
  task automatic clear_one_slot();
    int k;
    int s;
    s = -1;
    k = $urandom_range(0, SRR_SLOTS - 1);
    for (int i = 0; i < SRR_SLOTS; i++)
      if (s < 0 && sb.held[(k + i) % SRR_SLOTS]) s = (k + i) % SRR_SLOTS;
    if (s >= 0) begin
      send_item(OP_OPEN, sb.held_seq[s] - 16'd1, 16'($urandom));
      send_item(OP_DATA, sb.held_seq[s], 16'd0);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      1: send_item(OP_DATA, sb.ack_next - 16'($urandom_range(1, 32768)), 16'($urandom));
      2: send_item(OP_DATA, sb.ack_next + 16'($urandom_range(1, 32767)),
                   16'($urandom_range(0, 1500)));
      default: send_item(OP_DATA, sb.ack_next, 16'd0);
    endcase
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (sb.free_count() == 0 && r < 30) clear_one_slot();
    else if (r < 12) send_noise();
    else send_burst();
  endtask

  task automatic run_directed();
    send_item(OP_OPEN, 16'hFFFF, 16'hFFFF);   // ack point wraps to zero
    send_item(OP_DATA, 16'h0000, 16'h0000);   // zero-length, in order
    send_item(OP_DATA, 16'h0000, 16'hFFFF);   // longest segment
    send_item(OP_OPEN, 16'd99, 16'h0000);     // ack point 100
    send_item(OP_DATA, 16'd300, 16'd100);     // ahead, slot 0
    send_item(OP_DATA, 16'd200, 16'd100);     // ahead, slot 1
    send_item(OP_DATA, 16'd300, 16'd5);       // same seq already held
    send_item(OP_DATA, 16'd32867, 16'd1);     // farthest ahead distance
    send_item(OP_DATA, 16'd32868, 16'd7);     // half-range distance is old
    send_item(OP_DATA, 16'd99, 16'd10);       // just behind: old
    send_item(OP_DATA, 16'd100, 16'd100);     // drain needs two passes
    for (int k = 0; k < SRR_SLOTS - 1; k++)   // fill every remaining slot
      send_item(OP_DATA, 16'(2000 + 1000 * k), 16'd1000);
    send_item(OP_DATA, 16'd9000, 16'd1000);   // buffer full: dropped
    send_item(OP_OPEN, 16'd999, 16'h1234);    // reopen, slots stay
    send_item(OP_DATA, 16'd1000, 16'd1000);   // chains through seven slots
    send_item(OP_DATA, 16'd9000, 16'd23867);  // reaches the far segment
    send_item(OP_DATA, 16'd32868, 16'hFFFF);  // ack point wraps
    send_item(OP_DATA, 16'h0000, 16'hFFFF);   // ahead after wrap
  endtask

  initial begin
    int phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    // four phases of about a hundred beats each, each with its own idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 0 || ph == 2) hold_asked++;
      phase_start = beats_sent;
      while (beats_sent - phase_start < 100) random_step();
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES + 20) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/srr_pkg.sv
rtl/srr_slot_mem.sv
rtl/srr_ctrl.sv
rtl/segment_reorder_receiver.sv
tb/reorder_scoreboard_pkg.sv
tb/tb_top.sv
